### rtl/hbsa_pkg.sv
// Shared types and codes for the hierarchical bitmap slot allocator.
// No dependencies.
package hbsa_pkg;

	localparam int BIN_BITS = 32;
	localparam int BIN_LSB  = 5;

	localparam logic [2:0] ACT_MARK_USED  = 3'd0;
	localparam logic [2:0] ACT_MARK_FREE  = 3'd1;
	localparam logic [2:0] ACT_FIRST_FREE = 3'd2;
	localparam logic [2:0] ACT_FIRST_USED = 3'd3;
	localparam logic [2:0] ACT_NTH_USED   = 3'd4;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_USED     = 3'd1;
	localparam logic [2:0] ST_FREE     = 3'd2;
	localparam logic [2:0] ST_RANGE    = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

	typedef struct packed {
		logic [2:0] action;
		logic [9:0] index;
	} req_t;

	typedef struct packed {
		logic [9:0]  slot;
		logic [2:0]  status;
		logic [10:0] used_total;
	} rsp_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MARK,
		S_SRCH,
		S_NTH
	} state_t;

endpackage

### rtl/hbsa_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module hbsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/hierarchical_bitmap_slot_allocator.sv
// Top level of the hierarchical bitmap slot allocator.
// Depends on hbsa_pkg and hbsa_ram.
//
// One request at a time. Mark used, mark free, first free and first used
// register the request and pass through S_MARK or S_SRCH before done; a
// rejected request (range error, failed search, rank too large, unknown
// action) gives its result in the cycle after start. Nth used walks the leaf
// RAM one bin per cycle from bin 0 and answers from the bin that holds the
// rank. After reset and after every slot_count write the leaf RAM is cleared
// one bin per cycle, with busy high. Results appear for one cycle with done
// and cannot be held off.
module hierarchical_bitmap_slot_allocator
	import hbsa_pkg::*;
#(
	parameter int CAPACITY = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  req_t        req,
	output logic        done,
	output rsp_t        rsp,
	input  logic        cfg_we,
	input  logic [10:0] cfg_data
);

	localparam int NUM_BINS = (CAPACITY + BIN_BITS - 1) / BIN_BITS;
	localparam int BW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam int AW = BW + BIN_LSB + 2;

	state_t state_q, state_d;
	logic [10:0] sc_q;
	logic [10:0] total_q;
	logic [NUM_BINS-1:0] any_q, all_q;
	logic [BW-1:0] bin_q, clr_q;
	logic [10:0] acc_q;
	req_t req_q;
	logic done_q;
	rsp_t rsp_q;

	logic ram_we;
	logic [BW-1:0] ram_waddr, ram_raddr;
	logic [31:0] ram_wdata, ram_rdata;

	hbsa_ram #(.WIDTH(BIN_BITS), .DEPTH(1 << BW)) u_leaf (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	function automatic logic [31:0] bin_mask(logic [10:0] sc, logic [BW-1:0] b);
		logic [AW-1:0] base, rem;
		base = AW'({b, 5'd0});
		rem  = AW'(sc) - base;
		if (base >= AW'(sc)) begin
			return 32'd0;
		end else if (rem >= AW'(BIN_BITS)) begin
			return 32'hFFFFFFFF;
		end
		return (32'd1 << rem[4:0]) - 32'd1;
	endfunction

	function automatic logic [4:0] lowest_set(logic [31:0] x);
		logic [4:0] p;
		p = 5'd0;
		for (int i = 31; i >= 0; i--) begin
			if (x[i]) begin
				p = 5'(i);
			end
		end
		return p;
	endfunction

	function automatic logic [4:0] nth_set(logic [31:0] x, logic [5:0] n);
		logic [4:0] p;
		logic [31:0] m;
		p = 5'd0;
		for (int i = 0; i < 32; i++) begin
			m = (32'd2 << i) - 32'd1;
			if (x[i] && 6'($countones(x & m)) == n + 6'd1) begin
				p = 5'(i);
			end
		end
		return p;
	endfunction

	logic [NUM_BINS-1:0] act_bins, free_cand, used_cand;
	logic [BW-1:0] free_bin, used_bin, req_bin;
	logic free_hit, used_hit;

	always_comb begin
		for (int i = 0; i < NUM_BINS; i++) begin
			act_bins[i] = (AW'(i) << BIN_LSB) < AW'(sc_q);
		end
		free_cand = act_bins & ~all_q;
		used_cand = act_bins & any_q;
		free_hit = |free_cand;
		used_hit = |used_cand;
		free_bin = '0;
		used_bin = '0;
		for (int i = NUM_BINS - 1; i >= 0; i--) begin
			if (free_cand[i]) free_bin = BW'(i);
			if (used_cand[i]) used_bin = BW'(i);
		end
		req_bin = BW'(req.index >> BIN_LSB);
	end

	// Execute-stage values
	logic [31:0] cur_mask, bit_m, new_w, srch_w;
	logic [5:0]  cnt;
	logic [11:0] acc_sum;
	logic [10:0] rank;

	always_comb begin
		cur_mask = bin_mask(sc_q, bin_q);
		bit_m    = 32'd1 << req_q.index[4:0];
		new_w    = (req_q.action == ACT_MARK_USED) ? (ram_rdata | bit_m)
		                                           : (ram_rdata & ~bit_m);
		srch_w   = (req_q.action == ACT_FIRST_FREE) ? (~ram_rdata & cur_mask)
		                                            : (ram_rdata & cur_mask);
		cnt      = 6'($countones(ram_rdata));
		acc_sum  = 12'(acc_q) + 12'(cnt);
		rank     = {1'b0, req_q.index} - acc_q;
	end

	// Next state, RAM control
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = bin_q;
		ram_wdata = new_w;
		ram_raddr = req_bin;
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				if (clr_q == BW'(NUM_BINS - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				case (req.action)
					ACT_FIRST_FREE: ram_raddr = free_bin;
					ACT_FIRST_USED: ram_raddr = used_bin;
					ACT_NTH_USED:   ram_raddr = '0;
					default:        ram_raddr = req_bin;
				endcase
				if (cfg_we) begin
					state_d = S_CLEAR;
				end else if (start) begin
					case (req.action)
						ACT_MARK_USED, ACT_MARK_FREE:
							if ({1'b0, req.index} < sc_q) state_d = S_MARK;
						ACT_FIRST_FREE: if (free_hit) state_d = S_SRCH;
						ACT_FIRST_USED: if (used_hit) state_d = S_SRCH;
						ACT_NTH_USED:
							if ({1'b0, req.index} < total_q) state_d = S_NTH;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_MARK: begin
				ram_we  = (ram_rdata & bit_m) == ((req_q.action == ACT_MARK_USED) ? 32'd0 : bit_m);
				state_d = S_IDLE;
			end
			S_SRCH: state_d = S_IDLE;
			S_NTH: begin
				ram_raddr = bin_q + BW'(1);
				if (acc_sum > 12'({1'b0, req_q.index})) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
		if (cfg_we) state_d = S_CLEAR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			sc_q    <= 11'(CAPACITY > 2047 ? 2047 : CAPACITY);
			total_q <= '0;
			any_q   <= '0;
			all_q   <= '0;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			clr_q   <= (state_q == S_CLEAR && !cfg_we) ? clr_q + BW'(1) : '0;
			if (state_q == S_IDLE && start && state_d == S_IDLE) begin
				done_q <= 1'b1;
			end
			if (state_q == S_MARK) begin
				done_q <= 1'b1;
				if (ram_we) begin
					if (req_q.action == ACT_MARK_USED) begin
						total_q        <= total_q + 11'd1;
						any_q[bin_q]   <= 1'b1;
						all_q[bin_q]   <= (new_w & cur_mask) == cur_mask;
					end else begin
						total_q        <= total_q - 11'd1;
						any_q[bin_q]   <= (new_w & cur_mask) != 32'd0;
						all_q[bin_q]   <= 1'b0;
					end
				end
			end
			if (state_q == S_SRCH || (state_q == S_NTH && state_d == S_IDLE)) begin
				done_q <= 1'b1;
			end
			if (cfg_we) begin
				sc_q    <= ({21'd0, cfg_data} > 32'(CAPACITY)) ? 11'(CAPACITY) : cfg_data;
				total_q <= '0;
				any_q   <= '0;
				all_q   <= '0;
			end
		end
	end

	// Payload and result registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			req_q <= req;
			acc_q <= '0;
			case (req.action)
				ACT_FIRST_FREE: bin_q <= free_bin;
				ACT_FIRST_USED: bin_q <= used_bin;
				ACT_NTH_USED:   bin_q <= '0;
				default:        bin_q <= req_bin;
			endcase
			rsp_q.used_total <= total_q;
			case (req.action)
				ACT_MARK_USED, ACT_MARK_FREE: begin
					rsp_q.slot   <= req.index;
					rsp_q.status <= ST_RANGE;
				end
				ACT_FIRST_FREE, ACT_FIRST_USED, ACT_NTH_USED: begin
					rsp_q.slot   <= '0;
					rsp_q.status <= ST_NOTFOUND;
				end
				default: begin
					rsp_q.slot   <= '0;
					rsp_q.status <= ST_RANGE;
				end
			endcase
		end
		case (state_q)
			S_MARK: begin
				rsp_q.slot <= req_q.index;
				if (ram_we) begin
					rsp_q.status     <= ST_OK;
					rsp_q.used_total <= (req_q.action == ACT_MARK_USED) ?
					                    total_q + 11'd1 : total_q - 11'd1;
				end else begin
					rsp_q.status     <= (req_q.action == ACT_MARK_USED) ? ST_USED : ST_FREE;
					rsp_q.used_total <= total_q;
				end
			end
			S_SRCH: begin
				rsp_q.slot       <= 10'({bin_q, lowest_set(srch_w)});
				rsp_q.status     <= ST_OK;
				rsp_q.used_total <= total_q;
			end
			S_NTH: begin
				if (state_d == S_IDLE) begin
					rsp_q.slot       <= 10'({bin_q, nth_set(ram_rdata, rank[5:0])});
					rsp_q.status     <= ST_OK;
					rsp_q.used_total <= total_q;
				end else begin
					bin_q <= bin_q + BW'(1);
					acc_q <= acc_sum[10:0];
				end
			end
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !cfg_we) |=> (busy || done))
		else $error("accepted request neither in progress nor answered");

	a_total_changes_on_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(total_q != $past(total_q)) |-> ($past(state_q) == S_MARK || $past(cfg_we)))
		else $error("used total changed outside a mark");

	a_notfound_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == ST_NOTFOUND) |-> (rsp.slot == 10'd0))
		else $error("failed search reports a nonzero slot");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.used_total <= sc_q))
		else $error("used total exceeds active slot count");

endmodule
